[src/radial_profile_peak_and_divergence_macros.svh]
// Assertion macros shared by the radial profile checker.
`ifndef RADIAL_PROFILE_PEAK_AND_DIVERGENCE_MACROS_SVH
`define RADIAL_PROFILE_PEAK_AND_DIVERGENCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rppd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rppd: next-cycle check failed");

`endif

[src/rppd_pkg.sv]
// Shared widths, constants and beat types of the radial profile block.
package rppd_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int INDEX_WIDTH   = 16;
	localparam int CFG_WIDTH     = 8;

	// magnitudes of differences and of 2*|v| need one bit more than a value
	localparam int MAG_WIDTH  = VALUE_WIDTH + 1;
	// dividend is a magnitude shifted up by the fraction bits; quotient is as wide
	localparam int NUM_WIDTH  = MAG_WIDTH + FRACTION_BITS;
	localparam int SUM_WIDTH  = NUM_WIDTH + 1;
	localparam int STEP_WIDTH = $clog2(NUM_WIDTH);

	localparam logic [CFG_WIDTH-1:0]   CFG_RESET = CFG_WIDTH'(2);
	localparam logic [VALUE_WIDTH-2:0] SAT_MAX   = '1;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] radius;
		logic signed [VALUE_WIDTH-1:0] velocity;
		logic                          last_sample;
	} sample_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] peak_radius;
		logic        [VALUE_WIDTH-2:0] peak_speed;
		logic signed [VALUE_WIDTH-1:0] div_radius;
		logic signed [VALUE_WIDTH-1:0] div_velocity;
		logic        [VALUE_WIDTH-2:0] div_peak;
		logic                          zero_divisor_seen;
	} result_t;

endpackage

[src/rppd_divider.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module rppd_divider import rppd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_WIDTH-1:0] numerator,
	input  logic [MAG_WIDTH-1:0] divisor,
	output logic [NUM_WIDTH-1:0] quotient,
	output logic                 done
);

	// dividend shifts out at the top while quotient bits shift in at the bottom
	logic [NUM_WIDTH-1:0]  nq_q;
	logic [MAG_WIDTH-1:0]  rem_q;
	logic [MAG_WIDTH-1:0]  den_q;
	logic [STEP_WIDTH-1:0] count_q;
	logic                  busy_q;
	logic                  done_q;

	logic [MAG_WIDTH:0]   rem_shift;
	logic [MAG_WIDTH:0]   rem_diff;
	logic                 fits;

	assign rem_shift = {rem_q, nq_q[NUM_WIDTH-1]};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign fits      = rem_shift >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= STEP_WIDTH'(NUM_WIDTH - 1);
			end else if (busy_q) begin
				if (count_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= numerator;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			nq_q  <= {nq_q[NUM_WIDTH-2:0], fits};
			rem_q <= fits ? rem_diff[MAG_WIDTH-1:0] : rem_shift[MAG_WIDTH-1:0];
		end
	end

	assign quotient = nq_q;
	assign done     = done_q;

endmodule

[src/radial_profile_peak_and_divergence.sv]
// Top level: radial profile peak speed and spherical divergence tracker.
//
// Input channel (in_valid/in_ready/in_data): one beat per (radius, velocity) sample in
// signed Q16.16; last_sample closes the profile. Output channel (out_valid/out_ready/
// out_data): one beat per profile, produced on its last sample.
// Config: cfg_we/cfg_data write first_center_index at once; write it only while idle.
// Samples are taken one at a time: a sample whose window is evaluated passes PREP,
// DIV, SUM, UPD and FIN, waiting in DIV for the two 49-step bit-serial dividers that
// run side by side (2*v2/r2 and dv/dr); a sample with no window, or a zero divisor,
// goes from PREP straight to FIN. The result beat is loaded into the output register
// in FIN of the last sample.
// A pending result sits in the output register; the next profile is accepted while it
// waits, and only the next profile's last sample stalls until the receiver takes it.
// Reset (arst_n low) clears all stream state, drops out_valid and sets
// first_center_index back to 2.
module radial_profile_peak_and_divergence import rppd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sample_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output result_t              out_data,
	input  logic                 cfg_we,
	input  logic [CFG_WIDTH-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_SUM,
		S_UPD,
		S_FIN
	} state_t;

	state_t                 state_q;
	logic [CFG_WIDTH-1:0]   cfg_q;

	// held sample and the two before it
	sample_t                smp_q;
	value_t                 older_radius_q;
	value_t                 older_velocity_q;
	value_t                 prior_radius_q;
	value_t                 prior_velocity_q;
	logic [INDEX_WIDTH-1:0] index_q;

	// running bests
	logic [VALUE_WIDTH-1:0] best_speed_q;
	value_t                 best_speed_radius_q;
	logic [VALUE_WIDTH-2:0] best_div_q;
	value_t                 best_div_radius_q;
	value_t                 best_div_velocity_q;
	logic                   zero_flag_q;

	// window arithmetic
	logic                   neg_a_q;
	logic                   neg_b_q;
	logic [SUM_WIDTH-1:0]   mag_q;

	logic                   out_valid_q;
	result_t                out_q;

	// ---- window eligibility ----
	// a register value of zero behaves as one: the centre needs an older sample
	logic [CFG_WIDTH:0]     centre_min;
	logic                   eligible;

	assign centre_min = (cfg_q == '0) ? (CFG_WIDTH + 1)'(1) : {1'b0, cfg_q};
	// centre is the previous sample, index index_q - 1
	assign eligible   = index_q > INDEX_WIDTH'(centre_min);

	// ---- operand preparation ----
	value_t                 r1, r2, r3, v1, v2, v3;
	logic [MAG_WIDTH-1:0]   r1x, r2x, r3x, v1x, v2x, v3x;
	logic [MAG_WIDTH-1:0]   dr_up, dr_dn, dv_up, dv_dn;
	logic [MAG_WIDTH-1:0]   dr, dv, r2_mag, v2_mag, m2;
	logic                   dr_neg, dv_neg, zero_div;
	logic [NUM_WIDTH-1:0]   num_a, num_b;
	logic                   div_start;

	assign r1 = older_radius_q;
	assign r2 = prior_radius_q;
	assign r3 = smp_q.radius;
	assign v1 = older_velocity_q;
	assign v2 = prior_velocity_q;
	assign v3 = smp_q.velocity;

	assign r1x = {r1[VALUE_WIDTH-1], r1};
	assign r2x = {r2[VALUE_WIDTH-1], r2};
	assign r3x = {r3[VALUE_WIDTH-1], r3};
	assign v1x = {v1[VALUE_WIDTH-1], v1};
	assign v2x = {v2[VALUE_WIDTH-1], v2};
	assign v3x = {v3[VALUE_WIDTH-1], v3};

	// both orders in parallel, pick the non-negative one
	assign dr_up  = r3x - r1x;
	assign dr_dn  = r1x - r3x;
	assign dv_up  = v3x - v1x;
	assign dv_dn  = v1x - v3x;
	assign dr_neg = r3 < r1;
	assign dv_neg = v3 < v1;
	assign dr     = dr_neg ? dr_dn : dr_up;
	assign dv     = dv_neg ? dv_dn : dv_up;

	assign r2_mag = r2[VALUE_WIDTH-1] ? ('0 - r2x) : r2x;
	assign v2_mag = v2[VALUE_WIDTH-1] ? ('0 - v2x) : v2x;
	// |v2| <= 2^31, so doubling still fits the magnitude width
	assign m2     = {v2_mag[MAG_WIDTH-2:0], 1'b0};

	assign num_a  = {m2, {FRACTION_BITS{1'b0}}};
	assign num_b  = {dv, {FRACTION_BITS{1'b0}}};

	assign zero_div  = (r2 == '0) || (r3 == r1);
	assign div_start = (state_q == S_PREP) && eligible && !zero_div;

	// ---- dividers: 2*v2/r2 and dv/dr ----
	// quotients stay below 2^49, within the quotient width, so no clamp is needed
	logic [NUM_WIDTH-1:0]   qa, qb;
	logic                   done_a, done_b;

	rppd_divider u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.numerator (num_a),
		.divisor   (r2_mag),
		.quotient  (qa),
		.done      (done_a)
	);

	rppd_divider u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.numerator (num_b),
		.divisor   (dr),
		.quotient  (qb),
		.done      (done_b)
	);

	// ---- |qa +- qb| and saturation ----
	logic [SUM_WIDTH-1:0]   sum_add, sum_ab, sum_ba, mag_next;
	logic [VALUE_WIDTH-2:0] div_sat;

	assign sum_add  = {1'b0, qa} + {1'b0, qb};
	assign sum_ab   = {1'b0, qa} - {1'b0, qb};
	assign sum_ba   = {1'b0, qb} - {1'b0, qa};
	assign mag_next = (neg_a_q == neg_b_q) ? sum_add : ((qa >= qb) ? sum_ab : sum_ba);
	assign div_sat  = (mag_q[SUM_WIDTH-1:VALUE_WIDTH-1] != '0) ? SAT_MAX
		: mag_q[VALUE_WIDTH-2:0];

	// ---- peak speed ----
	// most negative velocity gives 2^31: it wins compares, reported as 2^31-1
	logic [VALUE_WIDTH-1:0] vel_bits, speed, best_speed_n;
	value_t                 best_speed_radius_n;
	logic [VALUE_WIDTH-2:0] peak_speed_n;
	logic                   take_speed;
	logic                   out_free;
	logic                   out_load;

	assign vel_bits            = smp_q.velocity;
	assign speed               = vel_bits[VALUE_WIDTH-1] ? ('0 - vel_bits) : vel_bits;
	assign take_speed          = (index_q == '0) || (speed > best_speed_q);
	assign best_speed_n        = take_speed ? speed : best_speed_q;
	assign best_speed_radius_n = take_speed ? smp_q.radius : best_speed_radius_q;
	assign peak_speed_n        = best_speed_n[VALUE_WIDTH-1] ? SAT_MAX
		: best_speed_n[VALUE_WIDTH-2:0];
	assign out_free            = !out_valid_q || out_ready;
	// result beat loaded on the last sample once the output register is free
	assign out_load            = (state_q == S_FIN) && smp_q.last_sample && out_free;

	// ---- control and stream state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= S_IDLE;
			cfg_q               <= CFG_RESET;
			older_radius_q      <= '0;
			older_velocity_q    <= '0;
			prior_radius_q      <= '0;
			prior_velocity_q    <= '0;
			index_q             <= '0;
			best_speed_q        <= '0;
			best_speed_radius_q <= '0;
			best_div_q          <= '0;
			best_div_radius_q   <= '0;
			best_div_velocity_q <= '0;
			zero_flag_q         <= 1'b0;
			out_valid_q         <= 1'b0;
			out_q               <= '0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (eligible && !zero_div) begin
						state_q <= S_DIV;
					end else begin
						// no window or zero divisor: skip to FIN; only a zero divisor raises the flag
						if (eligible) begin
							zero_flag_q <= 1'b1;
						end
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					if (done_a && done_b) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					// strictly greater only: an equal later window keeps the first
					if (div_sat > best_div_q) begin
						best_div_q          <= div_sat;
						best_div_radius_q   <= prior_radius_q;
						best_div_velocity_q <= prior_velocity_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!smp_q.last_sample) begin
						best_speed_q        <= best_speed_n;
						best_speed_radius_q <= best_speed_radius_n;
						older_radius_q      <= prior_radius_q;
						older_velocity_q    <= prior_velocity_q;
						prior_radius_q      <= smp_q.radius;
						prior_velocity_q    <= smp_q.velocity;
						if (index_q != '1) begin
							index_q <= index_q + 1'b1;
						end
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q.peak_radius           <= best_speed_radius_n;
						out_q.peak_speed            <= peak_speed_n;
						out_q.div_radius            <= best_div_radius_q;
						out_q.div_velocity          <= best_div_velocity_q;
						out_q.div_peak              <= best_div_q;
						out_q.zero_divisor_seen     <= zero_flag_q;
						// profile closed: back to a clean stream
						older_radius_q      <= '0;
						older_velocity_q    <= '0;
						prior_radius_q      <= '0;
						prior_velocity_q    <= '0;
						index_q             <= '0;
						best_speed_q        <= '0;
						best_speed_radius_q <= '0;
						best_div_q          <= '0;
						best_div_radius_q   <= '0;
						best_div_velocity_q <= '0;
						zero_flag_q         <= 1'b0;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			smp_q <= in_data;
		end
		if (state_q == S_PREP) begin
			neg_a_q <= v2[VALUE_WIDTH-1] ^ r2[VALUE_WIDTH-1];
			neg_b_q <= dv_neg ^ dr_neg;
		end
		if (state_q == S_SUM) begin
			mag_q <= mag_next;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[src/rppd_checker.sv]
// Port-level checker for the radial profile block, bound to the top level.
`include "radial_profile_peak_and_divergence_macros.svh"

module rppd_checker import rppd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	logic out_stall;
	logic in_take;
	logic no_window;
	logic centre_zero;

	assign out_stall   = out_valid && !out_ready;
	assign in_take     = in_valid && in_ready;
	assign no_window   = out_valid && (out_data.div_peak == '0);
	assign centre_zero = (out_data.div_radius == '0) && (out_data.div_velocity == '0);

	// a stalled result beat holds
	`RPPD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_data))

	// one sample at a time: busy for at least the cycle after an accepted beat
	`RPPD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_take, !in_ready)

	// no window kept means no centre reported
	`RPPD_ASSERT_SAME(a_empty_window, clk, arst_n, no_window, centre_zero)

	// a result is only produced while the input side is busy
	`RPPD_ASSERT_SAME(a_result_when_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind radial_profile_peak_and_divergence rppd_checker u_checker (.*);

[test/radial_profile_peak_and_divergence_tb.sv]
// Self-checking testbench for the radial profile peak speed and divergence tracker.
`timescale 1ns / 100ps

module radial_profile_peak_and_divergence_tb;
	import rppd_pkg::*;

	// ---------------------------------------------------------------------------------
	// DUT hookup
	// ---------------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	sample_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	result_t              out_data;
	logic                 cfg_we;
	logic [CFG_WIDTH-1:0] cfg_data;

	radial_profile_peak_and_divergence dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	// idle modes: which side of the link holds off, and how often
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// one row of the directed table; want is used only where typed is set
	typedef struct {
		sample_t beat;
		bit      typed;
		result_t want;
	} stim_row_t;

	localparam int  MAX_INDEX   = 2 ** INDEX_WIDTH - 1;
	// settle time for drain; covers the busy time of one evaluated window with margin
	localparam int  SETTLE_CYC  = 80;
	localparam real CLK_HALF_NS = 4.0;

	idle_mode_t  idle_mode;
	int          fail_count;
	result_t     awaited_summaries[$];
	stim_row_t   directed_rows[$];

	// ---------------------------------------------------------------------------------
	// Predictor state: mirror of the tracker's profile state and its register
	// ---------------------------------------------------------------------------------
	logic [CFG_WIDTH-1:0] centre_cfg;
	value_t               prev2_radius, prev2_velocity;
	value_t               prev_radius, prev_velocity;
	int                   samples_seen;
	bit [63:0]            top_speed;
	value_t               top_speed_radius;
	bit [63:0]            top_div;
	value_t               top_div_radius, top_div_velocity;
	bit                   divisor_zero_seen;

	function automatic void clear_profile();
		prev2_radius      = '0;
		prev2_velocity    = '0;
		prev_radius       = '0;
		prev_velocity     = '0;
		samples_seen      = 0;
		top_speed         = '0;
		top_speed_radius  = '0;
		top_div           = '0;
		top_div_radius    = '0;
		top_div_velocity  = '0;
		divisor_zero_seen = 1'b0;
	endfunction

	// Divergence of the window (prev2, prev, new): |2*v2/r2 + (v3-v1)/(r3-r1)|.
	// Quotients are magnitude divisions, truncated, sign put back after. With 32 bit
	// values the quotient stays below 2^49, so no quotient cap ever bites.
	function automatic void score_window(input value_t r3_in, input value_t v3_in);
		longint    r1, r2, r3, v1, v2, v3;
		longint    qa, qb, total;
		bit [63:0] dr, dv, m2, mr2, q, mag;
		r1 = prev2_radius;
		r2 = prev_radius;
		r3 = r3_in;
		v1 = prev2_velocity;
		v2 = prev_velocity;
		v3 = v3_in;
		if (r2 == 0 || r3 == r1) begin
			divisor_zero_seen = 1'b1;
			return;
		end
		dr  = (r3 < r1) ? r1 - r3 : r3 - r1;
		dv  = (v3 < v1) ? v1 - v3 : v3 - v1;
		m2  = (v2 < 0) ? -v2 : v2;
		m2  = m2 * 2;
		mr2 = (r2 < 0) ? -r2 : r2;
		q   = (m2 << FRACTION_BITS) / mr2;
		qa  = ((v2 < 0) != (r2 < 0)) ? -$signed(q) : $signed(q);
		q   = (dv << FRACTION_BITS) / dr;
		qb  = ((v3 < v1) != (r3 < r1)) ? -$signed(q) : $signed(q);
		total = qa + qb;
		mag   = (total < 0) ? -total : total;
		if (mag > SAT_MAX)
			mag = SAT_MAX;
		// strictly greater only: an equal (e.g. saturated) later window loses
		if (mag > top_div) begin
			top_div          = mag;
			top_div_radius   = prev_radius;
			top_div_velocity = prev_velocity;
		end
	endfunction

	// Fold one accepted sample into the profile; returns 1 with the summary on last.
	function automatic bit track_sample(input sample_t s, output result_t res);
		longint    vel;
		bit [63:0] speed;
		int        floor_idx;
		res       = '0;
		vel       = s.velocity;
		speed     = (vel < 0) ? -vel : vel;
		// a register value of 0 behaves as 1: a centre needs an older neighbour
		floor_idx = (centre_cfg == 0) ? 1 : centre_cfg;
		if (samples_seen == 0 || speed > top_speed) begin
			top_speed        = speed;
			top_speed_radius = s.radius;
		end
		// window is centred on the previous sample, index samples_seen - 1
		if (samples_seen >= 2 && samples_seen - 1 >= floor_idx)
			score_window(s.radius, s.velocity);
		prev2_radius   = prev_radius;
		prev2_velocity = prev_velocity;
		prev_radius    = s.radius;
		prev_velocity  = s.velocity;
		if (samples_seen < MAX_INDEX)
			samples_seen++;
		if (!s.last_sample)
			return 1'b0;
		res.peak_radius       = top_speed_radius;
		// most negative velocity wins at 2^31 but is reported as 2^31-1
		res.peak_speed        = (top_speed > SAT_MAX) ? SAT_MAX : top_speed[VALUE_WIDTH-2:0];
		res.div_radius        = top_div_radius;
		res.div_velocity      = top_div_velocity;
		res.div_peak          = top_div[VALUE_WIDTH-2:0];
		res.zero_divisor_seen = divisor_zero_seen;
		clear_profile();
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------------
	function automatic result_t summary(input value_t pr, input logic [VALUE_WIDTH-2:0] ps,
			input value_t dr, input value_t dv, input logic [VALUE_WIDTH-2:0] dp,
			input logic z);
		result_t r;
		r.peak_radius       = pr;
		r.peak_speed        = ps;
		r.div_radius        = dr;
		r.div_velocity      = dv;
		r.div_peak          = dp;
		r.zero_divisor_seen = z;
		return r;
	endfunction

	function automatic void add_row(input value_t r, input value_t v, input logic last,
			input bit typed = 1'b0, input result_t want = '0);
		stim_row_t row;
		row.beat.radius      = r;
		row.beat.velocity    = v;
		row.beat.last_sample = last;
		row.typed            = typed;
		row.want             = want;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic int sender_idle_pct();
		case (idle_mode)
			IDLE_SENDER: return 66;
			IDLE_BOTH:   return 33;
			default:     return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (idle_mode)
			IDLE_RECEIVER: return 66;
			IDLE_BOTH:     return 33;
			default:       return 0;
		endcase
	endfunction

	// any value the field allows, weighted towards extremes and small magnitudes
	function automatic value_t any_value();
		case ($urandom_range(5))
			0: begin
				case ($urandom_range(4))
					0:       return 32'sh7FFF_FFFF;
					1:       return 32'sh8000_0000;
					2:       return 32'sh0000_0000;
					3:       return 32'sh0000_0001;
					default: return -32'sd1;
				endcase
			end
			1, 2:    return $urandom;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	// Present one beat, hold it until accepted, then predict. Entered and left just
	// after a falling edge; valid stays high into the next call unless it idles.
	task automatic send_sample(input sample_t s, input bit typed = 1'b0,
			input result_t want = '0);
		result_t predicted;
		int      pct;
		pct = sender_idle_pct();
		if (pct > 0 && $urandom_range(7) == 0) begin
			// long gap now and then so that idle lands on every part of a divide
			in_valid = 1'b0;
			repeat ($urandom_range(1, 60)) @(negedge clk);
		end
		while ($urandom_range(99) < pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = s;
		do
			@(posedge clk);
		while (!in_ready);
		if (track_sample(s, predicted))
			awaited_summaries.insert(awaited_summaries.size(), typed ? want : predicted);
		@(negedge clk);
	endtask

	// let every awaited summary come back and the tracker fall idle
	task automatic drain();
		in_valid = 1'b0;
		while (awaited_summaries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_centre_floor(input logic [CFG_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we     = 1'b1;
		cfg_data   = val;
		centre_cfg = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Random profiles until about n_items beats went in. Most are physical-looking
	// (monotonic radius, smoothly drifting velocity); the rest are full-range noise
	// with repeated and zero radii thrown in.
	task automatic run_random_profiles(input int n_items);
		int      sent, len, i;
		bit      tidy, falling;
		sample_t s;
		value_t  r, v, step;
		sent = 0;
		while (sent < n_items) begin
			tidy    = ($urandom_range(9) < 7);
			falling = ($urandom_range(3) == 0);
			len     = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			r       = $urandom_range(1, 32'h0008_0000);
			v       = any_value();
			for (i = 0; i < len; i++) begin
				if (tidy) begin
					step = $urandom_range(1, 32'h0003_0000);
					r    = falling ? r - step : r + step;
					v    = ($urandom_range(7) == 0) ? any_value()
						: v + ($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
				end else begin
					case ($urandom_range(5))
						0:       r = '0;
						1:       r = prev2_radius;
						default: r = any_value();
					endcase
					v = any_value();
				end
				s.radius      = r;
				s.velocity    = v;
				s.last_sample = (i == len - 1);
				send_sample(s);
			end
			sent += len;
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Clock, receiver stalls and the result checker
	// ---------------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= receiver_stall_pct());
		end
	end

	task automatic check_field(input string label, input logic [VALUE_WIDTH-1:0] want,
			input logic [VALUE_WIDTH-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
			fail_count++;
		end
	endtask

	// each result beat is matched against the oldest awaited summary
	initial begin
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (awaited_summaries.size() == 0) begin
					$display("%0t: result beat with none awaited, actual %h", $time, out_data);
					fail_count++;
				end else begin
					want = awaited_summaries.pop_front();
					check_field("peak_radius", want.peak_radius, out_data.peak_radius);
					check_field("peak_speed", VALUE_WIDTH'(want.peak_speed),
						VALUE_WIDTH'(out_data.peak_speed));
					check_field("div_radius", want.div_radius, out_data.div_radius);
					check_field("div_velocity", want.div_velocity, out_data.div_velocity);
					check_field("div_peak", VALUE_WIDTH'(want.div_peak),
						VALUE_WIDTH'(out_data.div_peak));
					check_field("zero_divisor_seen", VALUE_WIDTH'(want.zero_divisor_seen),
						VALUE_WIDTH'(out_data.zero_divisor_seen));
				end
			end
		end
	end

	// Watchdog. About 520 beats; even with every beat opening a window behind the longest
	// sender gaps, the run ends well within the timeout.
	initial begin
		#8_000_000;
		$display("FAIL radial_profile_peak_and_divergence");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------------
	initial begin
		sample_t s;
		int      i;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		fail_count = 0;
		idle_mode  = IDLE_NONE;
		centre_cfg = CFG_RESET;
		clear_profile();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed table, register at its reset value (centre index 2) ---
		// single-beat profile straight after reset, most negative velocity
		add_row(32'sh0001_0000, 32'sh8000_0000, 1'b1, 1'b1,
			summary(32'sh0001_0000, SAT_MAX, '0, '0, '0, 1'b0));
		// two beats: field extremes, no window possible
		add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		add_row(32'sh8000_0000, 32'sh0000_0000, 1'b1, 1'b1,
			summary(32'sh7FFF_FFFF, 31'h7FFF_FFFF, '0, '0, '0, 1'b0));
		// zero centre radius: window skipped, flag raised
		add_row(32'sh0001_0000, '0, 1'b0);
		add_row(32'sh0002_0000, '0, 1'b0);
		add_row(32'sh0000_0000, '0, 1'b0);
		add_row(32'sh0003_0000, '0, 1'b1, 1'b1,
			summary(32'sh0001_0000, '0, '0, '0, '0, 1'b1));
		// zero spacing (r3 == r1): window skipped, flag raised
		add_row(32'sh0001_0000, '0, 1'b0);
		add_row(32'sh0002_0000, '0, 1'b0);
		add_row(32'sh0005_0000, '0, 1'b0);
		add_row(32'sh0002_0000, '0, 1'b1, 1'b1,
			summary(32'sh0001_0000, '0, '0, '0, '0, 1'b1));
		// extremes everywhere: saturated divergence, equal later window must not win
		add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		add_row(32'sh0000_0001, 32'sh7FFF_FFFF, 1'b0);
		add_row(32'sh8000_0000, 32'sh8000_0000, 1'b0);
		add_row(32'sh0000_0001, 32'sh8000_0000, 1'b0);
		add_row(-32'sd1, 32'sh1234_5678, 1'b0);
		add_row(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
		// gentle profile, plain divergence value
		add_row(32'sh0001_0000, 32'sh0001_0000, 1'b0);
		add_row(32'sh0002_0000, 32'sh0001_0000, 1'b0);
		add_row(32'sh0003_0000, 32'sh0001_0000, 1'b0);
		add_row(32'sh0004_0000, 32'sh0001_0000, 1'b1);
		foreach (directed_rows[k])
			send_sample(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);
		drain();

		// --- random phases, each with its own register value and idle pattern ---
		write_centre_floor(8'd1);
		idle_mode = IDLE_SENDER;
		run_random_profiles(55);
		drain();

		// zero behaves as one
		write_centre_floor(8'd0);
		idle_mode = IDLE_RECEIVER;
		run_random_profiles(55);
		drain();

		write_centre_floor(8'd4);
		idle_mode = IDLE_BOTH;
		run_random_profiles(55);
		drain();

		write_centre_floor(CFG_RESET);
		idle_mode = IDLE_NONE;
		run_random_profiles(55);
		drain();

		// --- top register value: windows only start at the 257th beat, centred on the 256th ---
		write_centre_floor(8'd255);
		idle_mode = IDLE_BOTH;
		for (i = 0; i < 262; i++) begin
			s.radius      = 32'sh0000_8000 * (i + 1);
			s.velocity    = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			s.last_sample = (i == 261);
			send_sample(s);
		end
		drain();

		if (fail_count == 0)
			$display("PASS radial_profile_peak_and_divergence");
		else
			$display("FAIL radial_profile_peak_and_divergence");
		$finish;
	end

endmodule
